// ===== hw/rtl/epsm_pkg.sv =====
// ----------------------------------------------------------------------------
// epsm_pkg: shared types and constants of the encoder period speed meter
// Operation codes, register indexes, sequencer states, fixed widths, IIR weights and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package epsm_pkg;

  // Fixed field widths
  localparam int unsigned OP_W       = 2;
  localparam int unsigned TCOUNT_W   = 16;
  localparam int unsigned SLOTS_W    = 10;
  localparam int unsigned RATE_W     = 20;
  localparam int unsigned TPERIOD_W  = 17;
  localparam int unsigned MINT_W     = 16;
  localparam int unsigned STALL_W    = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned PERIOD_W   = 24;
  localparam int unsigned SPEED_W    = 32;
  localparam int unsigned OVF_W      = 8;

  // Dividend is timer_rate shifted up by 16 fraction bits
  localparam int unsigned NUM_W      = RATE_W + 16;
  localparam int unsigned DIV_CNT_W  = $clog2(NUM_W);
  localparam int unsigned MIX_W      = 48;

  // IIR weights, 0.9 and 0.1 in Q0.16
  localparam logic [15:0] KEEP_WEIGHT = 16'd58982;
  localparam logic [15:0] NEW_WEIGHT  = 16'd6554;

  localparam logic [PERIOD_W-1:0] PERIOD_MAX = '1;
  localparam logic [SPEED_W-1:0]  SPEED_MAX  = '1;

  // Register reset values
  localparam logic [SLOTS_W-1:0]   SLOTS_RST   = 10'd50;
  localparam logic [RATE_W-1:0]    RATE_RST    = 20'd50000;
  localparam logic [TPERIOD_W-1:0] TPERIOD_RST = 17'd50000;
  localparam logic [MINT_W-1:0]    MINT_RST    = 16'd625;
  localparam logic [STALL_W-1:0]   STALL_RST   = 8'd2;

  typedef enum logic [OP_W-1:0] {
    OP_EDGE   = 2'd0,
    OP_WRAP   = 2'd1,
    OP_SAMPLE = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLOTS   = 3'd0,
    CFG_RATE    = 3'd1,
    CFG_TPERIOD = 3'd2,
    CFG_MINT    = 3'd3,
    CFG_STALL   = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PLUS,
    S_CHECK,
    S_DEN,
    S_DIV,
    S_KEEP,
    S_MIX,
    S_DONE
  } state_e;

endpackage

`default_nettype wire

// ===== hw/rtl/encoder_period_speed_meter_core.sv =====
// ----------------------------------------------------------------------------
// encoder_period_speed_meter_core: encoder speed from edge-to-edge period
// Period, glitch rejection, Q16.16 speed by restoring division, IIR smoothing.
// ----------------------------------------------------------------------------
// Sequence: wrap, sample and unused items go from idle straight to done; a
//   rejected edge passes plus and check; an accepted edge also passes den,
//   the 36-step restoring divider (one shared subtract/compare per cycle),
//   keep and mix. One item at a time: the next beat is taken once the
//   sequencer is back in idle, and the last result may wait while stalled.
// Reset: asynchronous; clears control, count and speed state, loads defaults.
`default_nettype none

module encoder_period_speed_meter_core #(
  parameter int unsigned COUNT_BITS = 16,
  parameter int unsigned WRAP_BITS  = 8
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  // input channel
  input  wire                                  in_valid_i,
  output logic                                 in_stall_o,
  input  wire  [epsm_pkg::OP_W-1:0]            operation_i,
  input  wire  [epsm_pkg::TCOUNT_W-1:0]        timer_count_i,
  // result channel
  output logic                                 out_valid_o,
  input  wire                                  out_stall_i,
  output logic [epsm_pkg::PERIOD_W-1:0]        period_ticks_o,
  output logic [epsm_pkg::SPEED_W-1:0]         speed_q16_o,
  output logic [epsm_pkg::SPEED_W-1:0]         smoothed_speed_q16_o,
  output logic [epsm_pkg::OVF_W-1:0]           overflow_count_o,
  output logic                                 edge_accepted_o,
  // configuration
  input  wire                                  cfg_we_i,
  input  wire  [epsm_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire  [epsm_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import epsm_pkg::*;

  localparam int unsigned PROD_W  = WRAP_BITS + TPERIOD_W;
  localparam int unsigned PLUS_W  = ((PROD_W > COUNT_BITS) ? PROD_W : COUNT_BITS) + 1;
  localparam int unsigned DEN_W   = PLUS_W + SLOTS_W;
  localparam int unsigned PWIDE_W = (PLUS_W > PERIOD_W) ? PLUS_W : PERIOD_W;
  localparam int unsigned SCMP_W  = (WRAP_BITS > STALL_W) ? WRAP_BITS : STALL_W;
  localparam int unsigned OCMP_W  = (WRAP_BITS > OVF_W) ? WRAP_BITS : OVF_W;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(NUM_W - 1);

  // configuration registers
  logic [SLOTS_W-1:0]   slots_q;
  logic [RATE_W-1:0]    rate_q;
  logic [TPERIOD_W-1:0] tperiod_q;
  logic [MINT_W-1:0]    mint_q;
  logic [STALL_W-1:0]   stall_q;

  // measurement state
  logic [COUNT_BITS-1:0] newer_q, cap_q;
  logic [WRAP_BITS-1:0]  wrap_q;
  logic [PERIOD_W-1:0]   period_reg_q;
  logic [SPEED_W-1:0]    speed_q, smooth_q;
  logic                  accepted_q;

  // datapath registers
  state_e                state_q, state_d;
  op_e                   op_q;
  logic [PLUS_W-1:0]     plus_q, period_q;
  logic [DEN_W-1:0]      den_q, rem_q;
  logic [NUM_W-1:0]      quot_q;
  logic [DIV_CNT_W-1:0]  cnt_q;
  logic [MIX_W-1:0]      mix_q;

  // output register
  logic                  out_valid_q;
  logic                  out_load;

  logic                  in_fire;
  logic [PLUS_W:0]       diff;
  logic                  diff_neg;
  logic                  glitch;
  logic [PWIDE_W-1:0]    period_wide;
  logic [DEN_W:0]        rem_sh;
  logic                  rem_ge;
  logic [DEN_W:0]        rem_sub;
  logic [SPEED_W-1:0]    speed_sat;
  logic [MIX_W-1:0]      mix_sum;
  logic [OCMP_W-1:0]     wrap_ext;

  assign in_fire  = in_valid_i && !in_stall_o;
  assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  // period and glitch test
  assign diff        = {1'b0, plus_q} - (PLUS_W + 1)'(newer_q);
  assign diff_neg    = diff[PLUS_W];
  assign glitch      = diff_neg || (diff[PLUS_W-1:0] <= PLUS_W'(mint_q));
  assign period_wide = PWIDE_W'(diff[PLUS_W-1:0]);

  // shared divider step: shift in one dividend bit, compare and subtract
  assign rem_sh  = {rem_q, quot_q[NUM_W-1]};
  assign rem_ge  = rem_sh >= (DEN_W + 1)'(den_q);
  assign rem_sub = rem_sh - (DEN_W + 1)'(den_q);

  // saturate the quotient to 32 bits
  assign speed_sat = (quot_q[NUM_W-1:SPEED_W] != '0) ? SPEED_MAX : quot_q[SPEED_W-1:0];
  assign mix_sum   = mix_q + MIX_W'(speed_q) * MIX_W'(NEW_WEIGHT);

  // extend the wrap count for the output field; a wider count is truncated there
  assign wrap_ext = OCMP_W'(wrap_q);

  // sequencer state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and handshake
  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          state_d = (op_e'(operation_i) == OP_EDGE) ? S_PLUS : S_DONE;
        end
      end
      S_PLUS:  state_d = S_CHECK;
      S_CHECK: state_d = glitch ? S_DONE : S_DEN;
      S_DEN:   state_d = S_DIV;
      S_DIV: begin
        if (cnt_q == DIV_LAST) begin
          state_d = S_KEEP;
        end
      end
      S_KEEP:  state_d = S_MIX;
      S_MIX:   state_d = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_q   <= SLOTS_RST;
      rate_q    <= RATE_RST;
      tperiod_q <= TPERIOD_RST;
      mint_q    <= MINT_RST;
      stall_q   <= STALL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_SLOTS:   slots_q   <= cfg_data_i[SLOTS_W-1:0];
        CFG_RATE:    rate_q    <= cfg_data_i[RATE_W-1:0];
        CFG_TPERIOD: tperiod_q <= cfg_data_i[TPERIOD_W-1:0];
        CFG_MINT:    mint_q    <= cfg_data_i[MINT_W-1:0];
        CFG_STALL:   stall_q   <= cfg_data_i[STALL_W-1:0];
        default: ;
      endcase
    end
  end

  // measurement state updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      newer_q      <= '0;
      wrap_q       <= '0;
      period_reg_q <= '0;
      speed_q      <= '0;
      smooth_q     <= '0;
      accepted_q   <= 1'b0;
      op_q         <= OP_NONE;
    end else begin
      if (in_fire) begin
        op_q       <= op_e'(operation_i);
        accepted_q <= 1'b0;
        // wrap and sample act at once
        unique case (op_e'(operation_i))
          OP_WRAP: begin
            if (wrap_q != '1) begin
              wrap_q <= wrap_q + WRAP_BITS'(1);
            end
          end
          OP_SAMPLE: begin
            if (SCMP_W'(wrap_q) >= SCMP_W'(stall_q)) begin
              speed_q  <= '0;
              smooth_q <= '0;
            end
          end
          OP_EDGE, OP_NONE: ;
          default: ;
        endcase
      end
      if (state_q == S_CHECK) begin
        // record the period, saturated; a negative one reads as zero
        if (diff_neg) begin
          period_reg_q <= '0;
        end else if (period_wide > PWIDE_W'(PERIOD_MAX)) begin
          period_reg_q <= PERIOD_MAX;
        end else begin
          period_reg_q <= period_wide[PERIOD_W-1:0];
        end
        // a glitch leaves the stored count alone
        if (!glitch) begin
          newer_q <= cap_q;
        end
      end
      if (state_q == S_KEEP) begin
        speed_q <= speed_sat;
      end
      if (state_q == S_MIX) begin
        smooth_q   <= mix_sum[SPEED_W+15:16];
        wrap_q     <= '0;
        accepted_q <= 1'b1;
      end
    end
  end

  // arithmetic datapath, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cap_q <= COUNT_BITS'(timer_count_i);
    end
    unique case (state_q)
      S_PLUS: begin
        plus_q <= PLUS_W'(PROD_W'(wrap_q) * PROD_W'(tperiod_q)) + PLUS_W'(cap_q);
      end
      S_CHECK: begin
        period_q <= diff[PLUS_W-1:0];
      end
      S_DEN: begin
        den_q  <= DEN_W'(slots_q) * DEN_W'(period_q);
        rem_q  <= '0;
        quot_q <= {rate_q, 16'd0};
        cnt_q  <= '0;
      end
      S_DIV: begin
        rem_q  <= rem_ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        quot_q <= {quot_q[NUM_W-2:0], rem_ge};
        cnt_q  <= cnt_q + DIV_CNT_W'(1);
      end
      S_KEEP: begin
        mix_q <= MIX_W'(smooth_q) * MIX_W'(KEEP_WEIGHT);
      end
      S_IDLE, S_MIX, S_DONE: ;
      default: ;
    endcase
  end

  // output register: load on finish, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      period_ticks_o       <= period_reg_q;
      speed_q16_o          <= speed_q;
      smoothed_speed_q16_o <= smooth_q;
      overflow_count_o     <= wrap_ext[OVF_W-1:0];
      edge_accepted_o      <= accepted_q && (op_q == OP_EDGE);
    end
  end

  assign out_valid_o = out_valid_q;

  // remainder stays below a nonzero divisor while dividing
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (den_q == '0) || (rem_q < den_q))
    else $error("divider remainder not below divisor");

  // divider runs exactly its step count before smoothing
  a_div_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) && (cnt_q == DIV_LAST) |=> (state_q == S_KEEP))
    else $error("divider did not finish on its last step");

  // an accepted edge clears the overflow count
  a_edge_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MIX) |=> (wrap_q == '0) && accepted_q)
    else $error("accepted edge left overflow count set");

  // a result claiming a new speed shows no overflows
  a_out_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && edge_accepted_o |-> (overflow_count_o == '0))
    else $error("edge result with nonzero overflow count");

  // input is only taken from idle; an edge beat starts the sequencer
  a_take_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (op_e'(operation_i) == OP_EDGE) |=> (state_q == S_PLUS))
    else $error("edge beat did not start the sequencer");

endmodule

`default_nettype wire
